>>> hw/rtl/assert_macros.svh
// assertion macros for the rtl files, included by tdpt_back
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef SYNTHESIS
`define ASSERT_CLK(lbl, clk, rstn, prop) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) (prop)) \
        else $error("assertion failed");
`define ASSERT_NEVER(lbl, clk, rstn, cond) \
    lbl: assert property (@(posedge clk) disable iff (!(rstn)) !(cond)) \
        else $error("forbidden condition");
`else
`define ASSERT_CLK(lbl, clk, rstn, prop)
`define ASSERT_NEVER(lbl, clk, rstn, cond)
`endif
`endif

>>> hw/rtl/tdpt_pkg.sv
// types and constants of the trial division prime test
package tdpt_pkg;

    localparam int LIMIT_BITS = 16;
    localparam int DIV_BITS   = LIMIT_BITS + 1;
    localparam int OUT_BYTES_BITS = 8;

    localparam logic [LIMIT_BITS-1:0] LIMIT_RESET = 16'd46341;
    localparam logic [LIMIT_BITS-1:0] FIRST_DIVISOR = 16'd3;

    typedef enum logic [1:0] {
        JOB_NOT_PRIME,
        JOB_PRIME,
        JOB_TRIAL
    } job_kind_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_DIV,
        BK_DONE
    } back_state_t;

endpackage

>>> hw/rtl/tdpt_front.sv
// front end: accepts candidates, settles trivial cases and sets the divisor bound
module tdpt_front #(
    parameter int VALUE_BITS = 32
) (
    input  logic                               s_valid,
    output logic                               s_ready,
    input  logic [VALUE_BITS-1:0]              candidate,
    input  logic [tdpt_pkg::LIMIT_BITS-1:0]    divisor_limit,
    output logic                               q_wr_valid,
    input  logic                               q_wr_ready,
    output tdpt_pkg::job_kind_t                job_kind,
    output logic [tdpt_pkg::LIMIT_BITS-1:0]    job_top,
    output logic [VALUE_BITS-1:0]              job_value
);
    import tdpt_pkg::*;

    localparam int CMP_BITS = (VALUE_BITS > LIMIT_BITS) ? VALUE_BITS : LIMIT_BITS;

    logic [CMP_BITS-1:0] n_ext;
    logic [CMP_BITS-1:0] limit_ext;
    logic [CMP_BITS-1:0] n_minus_one;

    assign n_ext       = CMP_BITS'(candidate);
    assign limit_ext   = CMP_BITS'(divisor_limit);
    assign n_minus_one = n_ext - CMP_BITS'(1);

    assign s_ready    = q_wr_ready;
    assign q_wr_valid = s_valid;
    assign job_value  = candidate;

    always_comb begin
        job_top = divisor_limit;
        if (candidate[VALUE_BITS-1]) begin
            job_kind = JOB_NOT_PRIME;
        end else if (n_ext < CMP_BITS'(2)) begin
            job_kind = JOB_NOT_PRIME;
        end else if (n_ext == CMP_BITS'(2)) begin
            job_kind = JOB_PRIME;
        end else if (!candidate[0]) begin
            job_kind = JOB_NOT_PRIME;
        end else begin
            job_kind = JOB_TRIAL;
            // small candidates stop one below themselves
            if (n_ext <= limit_ext) begin
                job_top = n_minus_one[LIMIT_BITS-1:0];
            end
        end
    end

endmodule

>>> hw/rtl/tdpt_queue.sv
// small register queue between front and back end
module tdpt_queue #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 2
) (
    input  logic             aclk,
    input  logic             aresetn,
    input  logic             wr_valid,
    output logic             wr_ready,
    input  logic [WIDTH-1:0] wr_data,
    output logic             rd_valid,
    input  logic             rd_en,
    output logic [WIDTH-1:0] rd_data
);
    localparam int PTR_BITS = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_BITS = $clog2(DEPTH + 1);

    logic [WIDTH-1:0]    entry_reg [DEPTH];
    logic [PTR_BITS-1:0] wptr_reg, wptr_next;
    logic [PTR_BITS-1:0] rptr_reg, rptr_next;
    logic [CNT_BITS-1:0] count_reg, count_next;
    logic                do_wr, do_rd;

    assign wr_ready = (count_reg != CNT_BITS'(DEPTH));
    assign rd_valid = (count_reg != '0);
    assign rd_data  = entry_reg[rptr_reg];
    assign do_wr    = wr_valid && wr_ready;
    assign do_rd    = rd_en && rd_valid;

    always_comb begin
        wptr_next  = wptr_reg;
        rptr_next  = rptr_reg;
        count_next = count_reg;
        if (do_wr) begin
            wptr_next = (wptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : wptr_reg + PTR_BITS'(1);
        end
        if (do_rd) begin
            rptr_next = (rptr_reg == PTR_BITS'(DEPTH - 1)) ? '0 : rptr_reg + PTR_BITS'(1);
        end
        if (do_wr && !do_rd) begin
            count_next = count_reg + CNT_BITS'(1);
        end else if (do_rd && !do_wr) begin
            count_next = count_reg - CNT_BITS'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wptr_reg  <= '0;
            rptr_reg  <= '0;
            count_reg <= '0;
        end else begin
            wptr_reg  <= wptr_next;
            rptr_reg  <= rptr_next;
            count_reg <= count_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (do_wr) begin
            entry_reg[wptr_reg] <= wr_data;
        end
    end

endmodule

>>> hw/rtl/tdpt_back.sv
// back end: bit-serial remainder over odd divisors and the result register
module tdpt_back #(
    parameter int VALUE_BITS = 32
) (
    input  logic                               aclk,
    input  logic                               aresetn,
    input  logic                               q_rd_valid,
    output logic                               q_rd_en,
    input  tdpt_pkg::job_kind_t                job_kind,
    input  logic [tdpt_pkg::LIMIT_BITS-1:0]    job_top,
    input  logic [VALUE_BITS-1:0]              job_value,
    output logic                               m_valid,
    input  logic                               m_ready,
    output logic                               m_is_prime
);
    import tdpt_pkg::*;
    `include "assert_macros.svh"

    localparam int CNT_BITS = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;

    back_state_t           state_reg, state_next;
    logic [VALUE_BITS-1:0] value_reg, value_next;
    logic [VALUE_BITS-1:0] shift_reg, shift_next;
    logic [LIMIT_BITS-1:0] top_reg, top_next;
    logic [DIV_BITS-1:0]   d_reg, d_next;
    logic [DIV_BITS-1:0]   r_reg, r_next;
    logic [CNT_BITS-1:0]   cnt_reg, cnt_next;
    logic                  result_reg, result_next;
    logic                  m_valid_reg, m_valid_next;
    logic                  m_prime_reg, m_prime_next;

    logic [DIV_BITS:0]     shifted;
    logic [DIV_BITS:0]     diff;
    logic [DIV_BITS-1:0]   r_step;
    logic [DIV_BITS-1:0]   d_plus;
    logic                  out_free;

    assign shifted  = {r_reg, shift_reg[VALUE_BITS-1]};
    assign diff     = shifted - {1'b0, d_reg};
    assign r_step   = (shifted >= {1'b0, d_reg}) ? diff[DIV_BITS-1:0] : shifted[DIV_BITS-1:0];
    assign d_plus   = d_reg + DIV_BITS'(2);
    assign out_free = !m_valid_reg || m_ready;

    assign m_valid    = m_valid_reg;
    assign m_is_prime = m_prime_reg;

    always_comb begin
        state_next   = state_reg;
        value_next   = value_reg;
        shift_next   = shift_reg;
        top_next     = top_reg;
        d_next       = d_reg;
        r_next       = r_reg;
        cnt_next     = cnt_reg;
        result_next  = result_reg;
        m_valid_next = m_valid_reg;
        m_prime_next = m_prime_reg;
        q_rd_en      = 1'b0;

        if (m_valid_reg && m_ready) begin
            m_valid_next = 1'b0;
        end

        unique case (state_reg)
            BK_IDLE: begin
                if (q_rd_valid) begin
                    q_rd_en    = 1'b1;
                    value_next = job_value;
                    shift_next = job_value;
                    top_next   = job_top;
                    d_next     = DIV_BITS'(FIRST_DIVISOR);
                    r_next     = '0;
                    cnt_next   = '0;
                    unique case (job_kind)
                        JOB_NOT_PRIME: begin
                            result_next = 1'b0;
                            state_next  = BK_DONE;
                        end
                        JOB_PRIME: begin
                            result_next = 1'b1;
                            state_next  = BK_DONE;
                        end
                        JOB_TRIAL: begin
                            if (job_top < FIRST_DIVISOR) begin
                                result_next = 1'b1;
                                state_next  = BK_DONE;
                            end else begin
                                state_next = BK_DIV;
                            end
                        end
                        default: begin
                            result_next = 1'b0;
                            state_next  = BK_DONE;
                        end
                    endcase
                end
            end
            BK_DIV: begin
                r_next     = r_step;
                shift_next = {shift_reg[VALUE_BITS-2:0], 1'b0};
                cnt_next   = cnt_reg + CNT_BITS'(1);
                if (cnt_reg == CNT_BITS'(VALUE_BITS - 1)) begin
                    // one remainder finished
                    if (r_step == '0) begin
                        result_next = 1'b0;
                        state_next  = BK_DONE;
                    end else if (d_plus > {1'b0, top_reg}) begin
                        result_next = 1'b1;
                        state_next  = BK_DONE;
                    end else begin
                        d_next     = d_plus;
                        r_next     = '0;
                        shift_next = value_reg;
                        cnt_next   = '0;
                    end
                end
            end
            BK_DONE: begin
                if (out_free) begin
                    m_valid_next = 1'b1;
                    m_prime_next = result_reg;
                    state_next   = BK_IDLE;
                end
            end
            default: begin
                state_next = BK_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg   <= BK_IDLE;
            m_valid_reg <= 1'b0;
        end else begin
            state_reg   <= state_next;
            m_valid_reg <= m_valid_next;
        end
    end

    always_ff @(posedge aclk) begin
        value_reg   <= value_next;
        shift_reg   <= shift_next;
        top_reg     <= top_next;
        d_reg       <= d_next;
        r_reg       <= r_next;
        cnt_reg     <= cnt_next;
        result_reg  <= result_next;
        m_prime_reg <= m_prime_next;
    end

    `ASSERT_CLK(a_divisor_odd, aclk, aresetn, (state_reg == BK_DIV) |-> d_reg[0])
    `ASSERT_CLK(a_rem_below_div, aclk, aresetn, (state_reg == BK_DIV) |-> (r_reg < d_reg))
    `ASSERT_CLK(a_div_in_bound, aclk, aresetn, (state_reg == BK_DIV) |-> (d_reg <= {1'b0, top_reg}))
    `ASSERT_CLK(a_done_emits, aclk, aresetn, (state_reg == BK_DONE && out_free) |=> (m_valid_reg && state_reg == BK_IDLE))
    `ASSERT_NEVER(a_pop_only_idle, aclk, aresetn, q_rd_en && state_reg != BK_IDLE)

endmodule

>>> hw/rtl/trial_division_prime_test.sv
// top level of the trial division prime test
// Each candidate on the slave stream yields one transaction on the master stream with
// bit 0 set when the candidate is prime. Negative values, zero, one and even values other
// than two are settled by the front end without trial division. An odd candidate is tried
// against odd divisors from 3 up to the smaller of candidate minus 1 and divisor_limit;
// each divisor goes through the bit-serial remainder unit of the back end, which takes
// one candidate at a time, so a large prime at the reset limit of 46341 meets every odd
// divisor up to it. The limit is written through cfg_we and cfg_wdata; the user must
// write it only while the block is idle, and the block itself does not enforce this.
// A limit below the square root of a candidate lets composites with only large factors
// through as prime. A two-entry queue lets the front end take new candidates while the
// back end is busy, and the result register lets the back end finish while a result waits.
module trial_division_prime_test #(
    parameter int VALUE_BITS = 32
) (
    input  logic                                  aclk,
    input  logic                                  aresetn,
    input  logic                                  cfg_we,
    input  logic [tdpt_pkg::LIMIT_BITS-1:0]       cfg_wdata,     // divisor_limit
    input  logic                                  s_axis_tvalid,
    output logic                                  s_axis_tready,
    input  logic [((VALUE_BITS+7)/8)*8-1:0]       s_axis_tdata,  // candidate
    output logic                                  m_axis_tvalid,
    input  logic                                  m_axis_tready,
    output logic [tdpt_pkg::OUT_BYTES_BITS-1:0]   m_axis_tdata   // is_prime, zero fill
);
    import tdpt_pkg::*;

    localparam int ENTRY_BITS = 2 + LIMIT_BITS + VALUE_BITS;

    logic [LIMIT_BITS-1:0] limit_reg;
    logic                  q_wr_valid, q_wr_ready;
    logic                  q_rd_valid, q_rd_en;
    job_kind_t             fr_kind, bk_kind;
    logic [LIMIT_BITS-1:0] fr_top, bk_top;
    logic [VALUE_BITS-1:0] fr_value, bk_value;
    logic [ENTRY_BITS-1:0] q_wr_data, q_rd_data;
    logic                  is_prime;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            limit_reg <= LIMIT_RESET;
        end else if (cfg_we) begin
            limit_reg <= cfg_wdata;
        end
    end

    tdpt_front #(
        .VALUE_BITS(VALUE_BITS)
    ) u_front (
        .s_valid      (s_axis_tvalid),
        .s_ready      (s_axis_tready),
        .candidate    (s_axis_tdata[VALUE_BITS-1:0]),
        .divisor_limit(limit_reg),
        .q_wr_valid   (q_wr_valid),
        .q_wr_ready   (q_wr_ready),
        .job_kind     (fr_kind),
        .job_top      (fr_top),
        .job_value    (fr_value)
    );

    assign q_wr_data = {fr_kind, fr_top, fr_value};

    tdpt_queue #(
        .WIDTH(ENTRY_BITS),
        .DEPTH(2)
    ) u_queue (
        .aclk    (aclk),
        .aresetn (aresetn),
        .wr_valid(q_wr_valid),
        .wr_ready(q_wr_ready),
        .wr_data (q_wr_data),
        .rd_valid(q_rd_valid),
        .rd_en   (q_rd_en),
        .rd_data (q_rd_data)
    );

    assign bk_kind  = job_kind_t'(q_rd_data[ENTRY_BITS-1 -: 2]);
    assign bk_top   = q_rd_data[VALUE_BITS +: LIMIT_BITS];
    assign bk_value = q_rd_data[VALUE_BITS-1:0];

    tdpt_back #(
        .VALUE_BITS(VALUE_BITS)
    ) u_back (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .q_rd_valid(q_rd_valid),
        .q_rd_en   (q_rd_en),
        .job_kind  (bk_kind),
        .job_top   (bk_top),
        .job_value (bk_value),
        .m_valid   (m_axis_tvalid),
        .m_ready   (m_axis_tready),
        .m_is_prime(is_prime)
    );

    assign m_axis_tdata = {{(OUT_BYTES_BITS-1){1'b0}}, is_prime};

endmodule
